// File: src/bre_pkg.sv
package bre_pkg;

    localparam int BITMAP_BYTES_DEF = 256;

    localparam int OP_W    = 3;
    localparam int START_W = 11;
    localparam int LEN_W   = 12;
    localparam int LIMIT_W = 12;
    localparam int RUN_W   = 12;
    localparam int CFG_W   = 9;
    localparam int CNT_W   = 13;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;
    localparam logic [RUN_W-1:0] RUN_MAX   = 12'hFFF;

    localparam logic [7:0] BYTE_FULL = 8'hFF;
    localparam logic [7:0] BYTE_LOW7 = 8'h7F;
    localparam logic [2:0] BIT_LAST  = 3'h7;

    localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
    localparam logic [OP_W-1:0] OP_SET   = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
    localparam logic [OP_W-1:0] OP_COUNT = 3'd3;
    localparam logic [OP_W-1:0] OP_EMPTY = 3'd4;

    // Control handed to the byte unit for one byte of the walk.
    typedef struct packed {
        logic       set_mode;
        logic [2:0] lo;
        logic [2:0] hi;
    } t_byte_ctl;

    // What the byte unit reports about the byte it was given.
    typedef struct packed {
        logic [7:0] wr_byte;
        logic [3:0] lead;
        logic       tail_full;
        logic       nonzero;
    } t_byte_res;

    // Leading ones of a byte, most significant bit first.
    function automatic logic [3:0] lead_ones(input logic [7:0] v);
        logic [3:0] n;
        logic       run;
        n   = 4'd0;
        run = 1'b1;
        for (int k = 7; k >= 0; k--) begin
            run = run & v[k];
            n   = n + {3'd0, run};
        end
        return n;
    endfunction

endpackage

// File: src/bre_in_if.sv
interface bre_in_if;
    import bre_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [START_W-1:0] start_bit;
    logic [LEN_W-1:0]   range_length;
    logic [LIMIT_W-1:0] count_limit;

    modport source(output valid, output operation, output start_bit,
                   output range_length, output count_limit, input ready);
    modport sink(input valid, input operation, input start_bit,
                 input range_length, input count_limit, output ready);
endinterface

// File: src/bre_out_if.sv
interface bre_out_if;
    import bre_pkg::*;

    logic             valid;
    logic             ready;
    logic [RUN_W-1:0] run_count;
    logic             is_empty;

    modport source(output valid, output run_count, output is_empty, input ready);
    modport sink(input valid, input run_count, input is_empty, output ready);
endinterface

// File: src/bre_byte_unit.sv
module bre_byte_unit (
    input  bre_pkg::t_byte_ctl i_ctl,
    input  logic [7:0]         i_byte,
    output bre_pkg::t_byte_res o_res
);
    import bre_pkg::*;

    logic [7:0] tail_mask;
    logic [7:0] range_mask;
    logic [7:0] tail;

    always_comb begin
        tail_mask  = BYTE_FULL >> i_ctl.lo;
        range_mask = tail_mask & ~(BYTE_LOW7 >> i_ctl.hi);
        tail       = i_byte & tail_mask;

        o_res.wr_byte   = i_ctl.set_mode ? (i_byte | range_mask) : (i_byte & ~range_mask);
        o_res.tail_full = (tail == tail_mask);
        o_res.lead      = lead_ones(8'(tail << i_ctl.lo));
        o_res.nonzero   = |i_byte;
    end

endmodule

// File: src/bitmap_range_engine.sv
// Channel  Direction  Payload                                            Handshake
// i_req    in         operation, start_bit, range_length, count_limit    valid/ready
// o_rsp    out        run_count, is_empty                                valid/ready
// i_cfg_*  in         bytes_in_use (9 bits)                              write enable
//
// One item is handled at a time; ready is high only while the sequencer is idle.
// Set, clear, count and is-empty read each byte and then evaluate it, in states
// S_RD and S_EXE; init writes one byte per cycle of the bytes in use.
// The single read port of the bitmap memory, read then evaluated, sets the pace.
// After reset a clearing pass zeroes every byte of the memory while ready is low.
// A finished result sits in the output register, so a stalled sink holds at most
// one result while the next item is already taken.
module bitmap_range_engine #(
    parameter int BITMAP_BYTES = bre_pkg::BITMAP_BYTES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [bre_pkg::CFG_W-1:0] i_cfg_wdata,
    bre_in_if.sink                   i_req,
    bre_out_if.source                o_rsp
);
    import bre_pkg::*;

    // Byte index width: it must reach BITMAP_BYTES itself and the last byte a
    // range can name (start plus length, in bytes, below 1024).
    localparam int BW = ($clog2(BITMAP_BYTES + 1) > 10) ? $clog2(BITMAP_BYTES + 1) : 10;
    localparam int AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam logic [BW-1:0] BB      = BW'(BITMAP_BYTES);
    localparam logic [BW-1:0] BB_LAST = BW'(BITMAP_BYTES - 1);

    typedef enum logic [5:0] {
        S_WIPE = 6'b000001,
        S_IDLE = 6'b000010,
        S_CLR  = 6'b000100,
        S_RD   = 6'b001000,
        S_EXE  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_cfg;
    logic [OP_W-1:0]    r_op, n_op;
    logic [2:0]         r_lo, n_lo;
    logic [2:0]         r_hi, n_hi;
    logic [LIMIT_W-1:0] r_limit, n_limit;
    logic [BW-1:0]      r_idx, n_idx;
    logic [BW-1:0]      r_end, n_end;
    logic               r_first, n_first;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [RUN_W-1:0]   r_run, n_run;
    logic               r_empty, n_empty;
    logic               r_out_valid, n_out_valid;
    logic [RUN_W-1:0]   r_out_run;
    logic               r_out_empty;
    logic [7:0]         r_rd_data;

    logic [7:0] r_mem [BITMAP_BYTES];

    logic          mem_we;
    logic [7:0]    mem_wdata;
    logic [BW-1:0] used;
    logic [BW-1:0] start_byte;
    logic [CNT_W-1:0] end_m1;
    logic [BW-1:0] last_raw;
    logic [BW-1:0] idx_inc;
    logic [CNT_W-1:0] cnt_full;
    logic          out_load;
    logic          is_write_op;

    t_byte_ctl byte_ctl;
    t_byte_res byte_res;

    bre_byte_unit u_byte_unit (
        .i_ctl  (byte_ctl),
        .i_byte (r_rd_data),
        .o_res  (byte_res)
    );

    // Init, count and is-empty cover only the bytes in use, capped at the store size.
    assign used = (BW'(r_cfg) < BB) ? BW'(r_cfg) : BB;

    assign start_byte = BW'(i_req.start_bit[START_W-1:3]);
    assign end_m1     = {2'b00, i_req.start_bit} + {1'b0, i_req.range_length} - 13'd1;
    assign last_raw   = BW'(end_m1[CNT_W-1:3]);
    assign idx_inc    = r_idx + BW'(1);

    assign is_write_op = (r_op == OP_SET) || (r_op == OP_CLEAR);

    // The high position only bounds the final byte of a set or clear range.
    always_comb begin
        byte_ctl.set_mode = (r_op == OP_SET);
        byte_ctl.lo       = r_first ? r_lo : 3'd0;
        byte_ctl.hi       = (is_write_op && (r_idx == r_end)) ? r_hi : BIT_LAST;
    end

    // On the first byte of a full tail the count starts at the tail length.
    assign cnt_full = r_first ? (13'd8 - {10'd0, r_lo}) : (r_count + 13'd8);

    assign i_req.ready = (r_state == S_IDLE);
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_limit   = r_limit;
        n_idx     = r_idx;
        n_end     = r_end;
        n_first   = r_first;
        n_count   = r_count;
        n_run     = r_run;
        n_empty   = r_empty;
        mem_we    = 1'b0;
        mem_wdata = 8'h00;

        unique case (r_state)
            S_WIPE: begin
                mem_we = 1'b1;
                n_idx  = idx_inc;
                if (r_idx == BB_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = i_req.operation;
                    n_lo    = i_req.start_bit[2:0];
                    n_limit = i_req.count_limit;
                    n_first = 1'b1;
                    n_run   = '0;
                    n_empty = 1'b0;
                    n_count = '0;
                    n_state = S_DONE;
                    unique case (i_req.operation)
                        OP_INIT: begin
                            n_idx = '0;
                            n_end = used;
                            if (used != '0) begin
                                n_state = S_CLR;
                            end
                        end
                        OP_SET, OP_CLEAR: begin
                            n_idx = start_byte;
                            if (last_raw > BB_LAST) begin
                                n_end = BB_LAST;
                                n_hi  = BIT_LAST;
                            end else begin
                                n_end = last_raw;
                                n_hi  = end_m1[2:0];
                            end
                            if ((i_req.range_length != '0) && (start_byte < BB)) begin
                                n_state = S_RD;
                            end
                        end
                        OP_COUNT: begin
                            n_idx = start_byte;
                            n_end = used;
                            if (start_byte < used) begin
                                n_state = S_RD;
                            end
                        end
                        OP_EMPTY: begin
                            n_idx = '0;
                            n_end = used;
                            if (used == '0) begin
                                n_empty = 1'b1;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CLR: begin
                mem_we = 1'b1;
                n_idx  = idx_inc;
                if (idx_inc == r_end) begin
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                n_state = S_EXE;
            end
            S_EXE: begin
                n_first = 1'b0;
                n_idx   = idx_inc;
                n_state = S_RD;
                if (is_write_op) begin
                    mem_we    = 1'b1;
                    mem_wdata = byte_res.wr_byte;
                    if (r_idx == r_end) begin
                        n_state = S_DONE;
                    end
                end else if (r_op == OP_COUNT) begin
                    if (!byte_res.tail_full) begin
                        n_count = (r_first ? '0 : r_count) + {9'd0, byte_res.lead};
                        n_state = S_DONE;
                    end else begin
                        n_count = cnt_full;
                        if (!((idx_inc < r_end) && (cnt_full < {1'b0, r_limit}))) begin
                            n_state = S_DONE;
                        end
                    end
                    n_run = (n_count > {1'b0, RUN_MAX}) ? RUN_MAX : n_count[RUN_W-1:0];
                end else begin
                    // Is-empty: stop at the first nonzero byte or after the last in use.
                    if (byte_res.nonzero) begin
                        n_state = S_DONE;
                    end else if (idx_inc == r_end) begin
                        n_empty = 1'b1;
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_WIPE;
                n_idx   = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WIPE;
            r_idx       <= '0;
            r_cfg       <= CFG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_limit <= n_limit;
        r_end   <= n_end;
        r_first <= n_first;
        r_count <= n_count;
        r_run   <= n_run;
        r_empty <= n_empty;
        if (out_load) begin
            r_out_run   <= r_run;
            r_out_empty <= r_empty;
        end
    end

    // Bitmap memory: one write and one registered read per cycle, same address.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx[AW-1:0]] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.run_count = r_out_run;
    assign o_rsp.is_empty  = r_out_empty;

endmodule

// File: src/bre_checker.sv
module bre_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [bre_pkg::RUN_W-1:0] i_run_count,
    input logic                     i_is_empty
);
    import bre_pkg::*;

    // A stalled result keeps its values.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_run_count)
            && $stable(i_is_empty))
        else $error("result changed while stalled");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an item is in work");

    // Reset empties the output and starts the clearing pass.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("block not quiet after reset");

    // A result answers one operation, so both fields are never set together.
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_is_empty && (i_run_count != '0)))
        else $error("count and empty flag both set");

endmodule

bind bitmap_range_engine bre_checker u_bre_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_run_count (o_rsp.run_count),
    .i_is_empty  (o_rsp.is_empty)
);

// File: verif/bitmap_check_pkg.sv
`timescale 1ns / 1ps

package bitmap_check_pkg;
    import bre_pkg::*;

    typedef struct packed {
        logic [RUN_W-1:0] run_count;
        logic             is_empty;
    } t_answer;

    // Keeps a private copy of the bitmap and the bytes_in_use register, works out
    // the answer of every accepted request, and compares returned answers in order.
    class bitmap_scoreboard;
        logic [7:0]       bitmap [BITMAP_BYTES_DEF];
        logic [CFG_W-1:0] bytes_in_use;
        t_answer          expected_answers [$];
        int               mismatches;

        function new();
            foreach (bitmap[i]) bitmap[i] = 8'h00;
            bytes_in_use = CFG_RESET;
            mismatches   = 0;
        endfunction

        function int leading_ones(logic [7:0] v);
            int n;
            n = 0;
            while (n < 8 && v[7 - n]) n++;
            return n;
        endfunction

        // Bits beyond the end of the store are dropped; bytes_in_use does not limit ranges.
        function void write_bits(logic [START_W-1:0] start, logic [LEN_W-1:0] len,
                                 logic value);
            int stop_at;
            stop_at = int'(start) + int'(len);
            for (int i = int'(start); i < stop_at; i++) begin
                if ((i >> 3) >= BITMAP_BYTES_DEF) break;
                bitmap[i >> 3][int'(BIT_LAST) - (i & int'(BIT_LAST))] = value;
            end
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [START_W-1:0] start,
                                   logic [LEN_W-1:0] len, logic [LIMIT_W-1:0] limit);
            t_answer    want;
            int         n, idx, first, run;
            logic [7:0] mask, tail;
            logic       walking;
            want = '0;
            n = (int'(bytes_in_use) < BITMAP_BYTES_DEF) ? int'(bytes_in_use) : BITMAP_BYTES_DEF;
            case (op)
                OP_INIT: begin
                    for (int i = 0; i < n; i++) bitmap[i] = 8'h00;
                end
                OP_SET:   write_bits(start, len, 1'b1);
                OP_CLEAR: write_bits(start, len, 1'b0);
                OP_COUNT: begin
                    idx   = int'(start) >> 3;
                    first = int'(start) & int'(BIT_LAST);
                    if (idx < n) begin
                        mask = BYTE_FULL >> first;
                        tail = bitmap[idx] & mask;
                        if (tail != mask) begin
                            tail = tail << first;
                            run  = leading_ones(tail);
                        end else begin
                            // The tail is full, so whole bytes are added until the limit,
                            // the end of the bytes in use, or a byte with a hole.
                            run     = 8 - first;
                            idx++;
                            walking = 1'b1;
                            while (walking && idx < n && run < int'(limit)) begin
                                if (bitmap[idx] == BYTE_FULL) begin
                                    run += 8;
                                end else begin
                                    run     += leading_ones(bitmap[idx]);
                                    walking  = 1'b0;
                                end
                                idx++;
                            end
                        end
                        want.run_count = (run > int'(RUN_MAX)) ? RUN_MAX : RUN_W'(run);
                    end
                end
                OP_EMPTY: begin
                    want.is_empty = 1'b1;
                    for (int i = 0; i < n; i++)
                        if (bitmap[i] != 8'h00) want.is_empty = 1'b0;
                end
                default: ;
            endcase
            expected_answers.push_back(want);
        endfunction

        function void check_answer(logic [RUN_W-1:0] run_count, logic is_empty);
            t_answer want;
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing pending: run_count=%0d is_empty=%0d",
                             run_count, is_empty);
                return;
            end
            want = expected_answers.pop_front();
            if (run_count !== want.run_count || is_empty !== want.is_empty) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: run_count exp %0d got %0d, is_empty exp %0d got %0d",
                             want.run_count, run_count, want.is_empty, is_empty);
            end
        endfunction
    endclass

endpackage

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bre_pkg::*;
    import bitmap_check_pkg::*;

    // The run is far shorter than this; the limit only catches a hung handshake.
    localparam int CYCLE_LIMIT = 2_000_000;
    // Longest single operation visits every byte once; the rest is margin.
    localparam int TAIL_CYCLES = 2 * BITMAP_BYTES_DEF + 64;
    localparam int SEGMENTS    = 8;
    localparam int SEG_ITEMS   = 60;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    bre_in_if  req_if();
    bre_out_if rsp_if();

    bitmap_range_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    bitmap_scoreboard sb;

    // Percent of cycles in which the request side holds back or the answer side stalls.
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    // Transfers of known operations on the request side; the unknown codes only
    // return zeros, so they do not push the stimulus forward.
    int ops_sent       = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a stuck handshake ends the run here.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL bitmap_range_engine");
        $finish;
    end

    // The answer side is ready or stalled per cycle. Changing ready on the falling
    // edge keeps it stable around the rising edge where the block samples it.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Everything is observed at the rising edge, before the block's own registers
    // update, so the transfer seen here is exactly the one the block takes. An answer
    // is checked before the request of the same edge is noted; the two never belong
    // to each other since an answer is loaded only after its request has been worked through.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.bytes_in_use = i_cfg_wdata;
            if (rsp_if.valid && rsp_if.ready)
                sb.check_answer(rsp_if.run_count, rsp_if.is_empty);
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.operation, req_if.start_bit,
                                req_if.range_length, req_if.count_limit);
        end
    end

    // Presents one request and returns right after the edge of its transfer. Valid is
    // left high; the next call either replaces the payload or drops valid for a gap,
    // so valid never gets two assignments on the same falling edge.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [START_W-1:0] start,
                             input logic [LEN_W-1:0] len, input logic [LIMIT_W-1:0] limit);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.operation    <= op;
        req_if.start_bit    <= start;
        req_if.range_length <= len;
        req_if.count_limit  <= limit;
        do @(posedge i_clk); while (!req_if.ready);
        if (op <= OP_EMPTY) ops_sent++;
    endtask

    // Holds the request side off until every answer is back and the block takes
    // requests again. Also covers the clearing pass that follows reset.
    task automatic drain();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (sb.expected_answers.size() != 0 || !req_if.ready) @(posedge i_clk);
    endtask

    // The register is only written while the block is idle.
    task automatic write_bytes_in_use(input logic [CFG_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One reassembly-like episode: clear the window, then fill it mostly in order
    // with the odd hole, back-fill, clear pieces, and ask for the run length and
    // emptiness along the way. The start is placed inside the bytes in use so that
    // the count walk actually gets going; fields an operation ignores get random bits.
    task automatic run_episode();
        int base, cursor, used, pick, len, n_steps;
        used = (int'(sb.bytes_in_use) < BITMAP_BYTES_DEF) ?
               int'(sb.bytes_in_use) : BITMAP_BYTES_DEF;
        base = (used > 0) ? $urandom_range(0, used * 8 - 1) : $urandom_range(0, 2047);
        cursor  = 0;
        n_steps = $urandom_range(6, 16);
        send_item(OP_INIT, START_W'($urandom), LEN_W'($urandom), LIMIT_W'($urandom));
        repeat (n_steps) begin
            pick = $urandom_range(0, 99);
            // Mostly short ranges; now and then one spanning tens of bytes.
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 400) : $urandom_range(1, 40);
            if (pick < 50) begin
                if ($urandom_range(0, 4) == 0) cursor += $urandom_range(1, 12);
                send_item(OP_SET, START_W'(base + cursor), LEN_W'(len), LIMIT_W'($urandom));
                cursor += len;
            end else if (pick < 60) begin
                send_item(OP_SET, START_W'(base + $urandom_range(0, cursor)),
                          LEN_W'(len % 16 + 1), LIMIT_W'($urandom));
            end else if (pick < 70) begin
                send_item(OP_CLEAR, START_W'(base + $urandom_range(0, cursor)),
                          LEN_W'(len % 12 + 1), LIMIT_W'($urandom));
            end else if (pick < 92) begin
                send_item(OP_COUNT,
                          START_W'(($urandom_range(0, 9) < 6) ?
                                   base : base + $urandom_range(0, cursor + 8)),
                          LEN_W'($urandom),
                          LIMIT_W'(($urandom_range(0, 1) == 0) ?
                                   int'(RUN_MAX) : $urandom_range(0, cursor + 16)));
            end else begin
                send_item(OP_EMPTY, START_W'($urandom), LEN_W'($urandom), LIMIT_W'($urandom));
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] cfg_plan [SEGMENTS];
        int               target;
        bit               paused;

        sb = new();
        // Every input is known from time zero while reset is held.
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        req_if.valid        = 1'b0;
        req_if.operation    = OP_INIT;
        req_if.start_bit    = '0;
        req_if.range_length = '0;
        req_if.count_limit  = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, at the reset value of bytes_in_use and without idling.
        // The first request waits out the clearing pass on its own.
        send_item(OP_EMPTY, '0, '0, '0);
        send_item(OP_COUNT, '0, '0, RUN_MAX);
        // A zero length range changes nothing.
        send_item(OP_SET, '0, '0, '0);
        // Longest possible range fills the store; bits past the end are dropped.
        send_item(OP_SET, '0, '1, '1);
        send_item(OP_COUNT, '0, '0, RUN_MAX);
        // Last bit of the store, and a limit of zero that stops after the first tail.
        send_item(OP_COUNT, '1, '1, '0);
        send_item(OP_COUNT, START_W'(5), '0, '0);
        send_item(OP_EMPTY, '1, '1, '1);
        send_item(OP_CLEAR, '1, '1, '0);
        send_item(OP_COUNT, START_W'(2040), '0, RUN_MAX);
        send_item(OP_CLEAR, START_W'(1000), LEN_W'(24), '0);
        send_item(OP_COUNT, START_W'(8), '0, RUN_MAX);
        send_item(OP_COUNT, START_W'(8), '0, LIMIT_W'(16));
        // The unknown operation codes must change nothing and return zeros.
        for (int k = int'(OP_EMPTY) + 1; k < (1 << OP_W); k++)
            send_item(OP_W'(k), '1, '1, '1);
        send_item(OP_SET, '1, LEN_W'(1), '0);
        send_item(OP_INIT, '1, '1, '1);
        send_item(OP_EMPTY, '0, '0, '0);
        // A short run that starts inside a byte and ends inside it.
        send_item(OP_SET, START_W'(3), LEN_W'(2), '0);
        send_item(OP_COUNT, START_W'(3), '0, RUN_MAX);
        send_item(OP_COUNT, START_W'(4), '0, RUN_MAX);
        send_item(OP_COUNT, '0, '0, RUN_MAX);
        send_item(OP_EMPTY, '0, '0, '0);
        send_item(OP_CLEAR, '0, LEN_W'(2048), '0);
        send_item(OP_EMPTY, '0, '0, '0);

        // Random part in segments, each with its own bytes_in_use and idling pattern.
        // Zero covers no bytes at all, and 511 is above the store size, so the
        // effective value is clipped to the store.
        cfg_plan = '{9'd1, 9'd0, 9'd511, 9'd256, 9'd3, 9'd0, 9'd32, 9'd0};
        cfg_plan[5] = CFG_W'($urandom_range(1, 256));
        cfg_plan[7] = CFG_W'($urandom_range(0, 511));
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            write_bytes_in_use(cfg_plan[seg]);
            case (seg % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 51;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 51;
                end
                default: begin
                    src_idle_pct   = 6;
                    sink_stall_pct = 6;
                end
            endcase
            target = ops_sent + SEG_ITEMS;
            paused = 1'b0;
            while (ops_sent < target) begin
                // Halfway through, let the block run completely dry once.
                if (!paused && ops_sent >= target - SEG_ITEMS / 2) begin
                    drain();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 99) < 80) begin
                    run_episode();
                end else begin
                    // Noise: any code, any start, sometimes a range across the end.
                    send_item(OP_W'($urandom_range(0, (1 << OP_W) - 1)), START_W'($urandom),
                              LEN_W'(($urandom_range(0, 9) < 7) ?
                                     $urandom_range(0, 64) : $urandom),
                              LIMIT_W'($urandom));
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_answers.size() == 0) begin
            $display("PASS bitmap_range_engine");
        end else begin
            $display("FAIL bitmap_range_engine");
        end
        $finish;
    end

endmodule

// File: files.f
src/bre_pkg.sv
src/bre_in_if.sv
src/bre_out_if.sv
src/bre_byte_unit.sv
src/bitmap_range_engine.sv
src/bre_checker.sv
verif/bitmap_check_pkg.sv
verif/tb_top.sv
